// ----- rtl/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// rss_pkg: shared constants and types for the running sample statistics block
// Field widths, saturation limits and the divider request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int SAMPLE_BITS = 24;

  localparam int SMP_W  = 24;
  localparam int CNT_W  = 16;
  localparam int CLS_W  = 2;
  localparam int SUM_W  = 40;
  localparam int SQ_W   = 62;
  localparam int VAR_W  = 48;
  localparam int PROD_W = 2 * SMP_W;

  localparam int DIV_BITS     = SQ_W;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam logic [CLS_W-1:0] CLS_FINITE = 2'd0;
  localparam logic [CLS_W-1:0] CLS_INF    = 2'd1;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic signed [SMP_W-1:0] SMP_MAX = SMP_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SMP_W-1:0] SMP_MIN = SMP_W'(-(1 << (SAMPLE_BITS - 1)));

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  localparam logic signed [SMP_W-1:0] AVG_MAX     = {1'b0, {(SMP_W - 1){1'b1}}};
  localparam logic signed [SMP_W-1:0] AVG_MIN     = {1'b1, {(SMP_W - 1){1'b0}}};
  localparam logic [DIV_BITS-1:0]     AVG_NEG_LIM = DIV_BITS'(1) << (SMP_W - 1);

  typedef struct packed {
    logic                  start;
    logic [DIV_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/rss_if.sv -----
// ----------------------------------------------------------------------------
// rss_if: sample and result channels of the running sample statistics block
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rss_pkg::SMP_W-1:0]    sample;
  logic        [rss_pkg::CLS_W-1:0]    sample_class;
  logic                                last_sample;

  modport source (output valid, output sample, output sample_class, output last_sample,
                  input ready);
  modport sink   (input valid, input sample, input sample_class, input last_sample,
                  output ready);
endinterface

interface rss_out_if;
  logic                                valid;
  logic                                ready;
  logic        [rss_pkg::CNT_W-1:0]    total_count;
  logic        [rss_pkg::CNT_W-1:0]    nan_count;
  logic        [rss_pkg::CNT_W-1:0]    inf_count;
  logic        [rss_pkg::CNT_W-1:0]    normal_count;
  logic signed [rss_pkg::SUM_W-1:0]    sum_out;
  logic signed [rss_pkg::SMP_W-1:0]    average;
  logic        [rss_pkg::VAR_W-1:0]    variance;
  logic signed [rss_pkg::SMP_W-1:0]    minimum;
  logic signed [rss_pkg::SMP_W-1:0]    maximum;
  logic                                no_finite;

  modport source (output valid, output total_count, output nan_count, output inf_count,
                  output normal_count, output sum_out, output average, output variance,
                  output minimum, output maximum, output no_finite, input ready);
  modport sink   (input valid, input total_count, input nan_count, input inf_count,
                  input normal_count, input sum_out, input average, input variance,
                  input minimum, input maximum, input no_finite, output ready);
endinterface

`default_nettype wire

// ----- rtl/rss_div.sv -----
// ----------------------------------------------------------------------------
// rss_div: shared restoring divider
// Unsigned dividend by count divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rss_pkg::div_req_t req,
  output rss_pkg::div_rsp_t      rsp
);

  logic [rss_pkg::DIV_BITS-1:0]     quo_r;
  logic [rss_pkg::DIV_BITS-1:0]     quo_nxt;
  logic [rss_pkg::COUNT_BITS-1:0]   rem_r;
  logic [rss_pkg::COUNT_BITS-1:0]   rem_nxt;
  logic [rss_pkg::COUNT_BITS-1:0]   dvs_r;
  logic [rss_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [rss_pkg::COUNT_BITS:0]     trial;
  logic                             fits;

  always_comb begin
    trial = {rem_r, quo_r[rss_pkg::DIV_BITS-1]};
    fits  = (trial >= {1'b0, dvs_r});
    if (fits) begin
      rem_nxt = rss_pkg::COUNT_BITS'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[rss_pkg::COUNT_BITS-1:0];
    end
    quo_nxt = {quo_r[rss_pkg::DIV_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      quo_r  <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == rss_pkg::DIV_CNT_BITS'(rss_pkg::DIV_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/running_sample_statistics_top.sv -----
// ----------------------------------------------------------------------------
// running_sample_statistics_top: running count, mean, variance, min and max
// Accumulates tagged fixed-point samples and reports statistics per data set.
// ----------------------------------------------------------------------------
// Samples arrive on in_ch, one item per handshake, each with a class tag and a
// last flag. Finite samples update the sum, sum of squares, minimum, maximum
// and finite count; every sample bumps the total and its class counter, all
// counters saturating. A sample is squared on the shared multiplier and then
// accumulated, and a sample without the last flag then frees the input. A
// sample with the last flag is accumulated and then, if any finite sample
// came, the shared divider runs twice, 62 steps each, for the average and
// the mean square, and the multiplier squares the average; the result item
// is published once the output register is free. Input ready is low
// during all of that work. The result sits in an output register on out_ch;
// if the receiver stalls, the next data set is still accumulated, and the
// block only waits before publishing its next result. After each result, and
// at synchronous reset, all accumulators return to empty with minimum at the
// largest and maximum at the smallest sample value.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rss_in_if.sink     in_ch,
  rss_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_ACCUM,
    ST_PREP,
    ST_DIV_SUM,
    ST_AVG_FIX,
    ST_DIV_SQ,
    ST_MUL_AVG,
    ST_VAR,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic signed [rss_pkg::SMP_W-1:0]  smp_r;
  logic        [rss_pkg::CLS_W-1:0]  cls_r;
  logic                              last_r;
  logic        [rss_pkg::PROD_W-1:0] prod_r;

  logic signed [rss_pkg::SUM_W-1:0]      acc_sum_r;
  logic        [rss_pkg::SQ_W-1:0]       acc_sum_sq_r;
  logic signed [rss_pkg::SMP_W-1:0]      run_min_r;
  logic signed [rss_pkg::SMP_W-1:0]      run_max_r;
  logic        [rss_pkg::COUNT_BITS-1:0] finite_cnt_r;
  logic        [rss_pkg::COUNT_BITS-1:0] nan_cnt_r;
  logic        [rss_pkg::COUNT_BITS-1:0] inf_cnt_r;
  logic        [rss_pkg::COUNT_BITS-1:0] all_cnt_r;

  logic                              none_r;
  logic signed [rss_pkg::SMP_W-1:0]  avg_r;
  logic        [rss_pkg::VAR_W-1:0]  var_r;

  logic                              out_valid_r;
  logic        [rss_pkg::CNT_W-1:0]  o_total_r;
  logic        [rss_pkg::CNT_W-1:0]  o_nan_r;
  logic        [rss_pkg::CNT_W-1:0]  o_inf_r;
  logic        [rss_pkg::CNT_W-1:0]  o_normal_r;
  logic signed [rss_pkg::SUM_W-1:0]  o_sum_r;
  logic signed [rss_pkg::SMP_W-1:0]  o_avg_r;
  logic        [rss_pkg::VAR_W-1:0]  o_var_r;
  logic signed [rss_pkg::SMP_W-1:0]  o_min_r;
  logic signed [rss_pkg::SMP_W-1:0]  o_max_r;
  logic                              o_none_r;

  logic                              in_fire;
  logic                              out_fire;
  logic                              out_free;
  logic signed [rss_pkg::SMP_W-1:0]  in_smp;
  logic signed [rss_pkg::SMP_W-1:0]  mul_a;
  logic signed [rss_pkg::PROD_W-1:0] mul_p;
  logic signed [rss_pkg::SUM_W:0]    sum_ext;
  logic signed [rss_pkg::SUM_W-1:0]  sum_sat;
  logic        [rss_pkg::SQ_W:0]     sq_ext;
  logic        [rss_pkg::SQ_W-1:0]   sq_sat;
  logic        [rss_pkg::SUM_W-1:0]  sum_mag;
  logic                              sum_neg;
  logic        [rss_pkg::DIV_BITS-1:0] quo;
  logic signed [rss_pkg::SMP_W-1:0]  avg_fix;
  logic        [rss_pkg::SQ_W-1:0]   msq_diff;
  logic        [rss_pkg::VAR_W-1:0]  var_fix;

  rss_pkg::div_req_t div_req;
  rss_pkg::div_rsp_t div_rsp;

  rss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign in_smp = rss_pkg::SMP_W'(signed'(in_ch.sample[rss_pkg::SAMPLE_BITS-1:0]));

  // The one multiplier squares the sample, and later the average.
  assign mul_a = (state_r == ST_MUL_SQ) ? smp_r : avg_r;
  assign mul_p = mul_a * mul_a;

  always_comb begin
    sum_ext = {acc_sum_r[rss_pkg::SUM_W-1], acc_sum_r} + (rss_pkg::SUM_W + 1)'(smp_r);
    if (sum_ext[rss_pkg::SUM_W] != sum_ext[rss_pkg::SUM_W-1]) begin
      sum_sat = sum_ext[rss_pkg::SUM_W] ? rss_pkg::SUM_MIN : rss_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_ext[rss_pkg::SUM_W-1:0];
    end

    sq_ext = {1'b0, acc_sum_sq_r} + (rss_pkg::SQ_W + 1)'(prod_r);
    sq_sat = sq_ext[rss_pkg::SQ_W] ? rss_pkg::SQ_MAX : sq_ext[rss_pkg::SQ_W-1:0];

    sum_neg = acc_sum_r[rss_pkg::SUM_W-1];
    sum_mag = sum_neg ? rss_pkg::SUM_W'(-acc_sum_r) : rss_pkg::SUM_W'(acc_sum_r);

    quo = div_rsp.quotient;
    if (sum_neg) begin
      if (quo > rss_pkg::AVG_NEG_LIM) begin
        avg_fix = rss_pkg::AVG_MIN;
      end else begin
        avg_fix = -(rss_pkg::SMP_W'(quo));
      end
    end else begin
      if (quo > rss_pkg::DIV_BITS'(rss_pkg::AVG_MAX)) begin
        avg_fix = rss_pkg::AVG_MAX;
      end else begin
        avg_fix = rss_pkg::SMP_W'(quo);
      end
    end

    msq_diff = quo - rss_pkg::SQ_W'(prod_r);
    if (quo > rss_pkg::SQ_W'(prod_r)) begin
      if (msq_diff > rss_pkg::SQ_W'(rss_pkg::VAR_MAX)) begin
        var_fix = rss_pkg::VAR_MAX;
      end else begin
        var_fix = msq_diff[rss_pkg::VAR_W-1:0];
      end
    end else begin
      var_fix = '0;
    end

    div_req.start    = ((state_r == ST_PREP) && (finite_cnt_r != '0)) ||
                       (state_r == ST_AVG_FIX);
    div_req.dividend = (state_r == ST_PREP) ? rss_pkg::DIV_BITS'(sum_mag) : acc_sum_sq_r;
    div_req.divisor  = finite_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      acc_sum_r    <= '0;
      acc_sum_sq_r <= '0;
      run_min_r    <= rss_pkg::SMP_MAX;
      run_max_r    <= rss_pkg::SMP_MIN;
      finite_cnt_r <= '0;
      nan_cnt_r    <= '0;
      inf_cnt_r    <= '0;
      all_cnt_r    <= '0;
      none_r       <= 1'b0;
    end else begin
      if (out_fire && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            smp_r   <= in_smp;
            cls_r   <= in_ch.sample_class;
            last_r  <= in_ch.last_sample;
            state_r <= ST_MUL_SQ;
          end
        end
        ST_MUL_SQ: begin
          prod_r  <= unsigned'(mul_p);
          state_r <= ST_ACCUM;
        end
        ST_ACCUM: begin
          if (all_cnt_r != rss_pkg::CNT_MAX) begin
            all_cnt_r <= all_cnt_r + 1'b1;
          end
          if (cls_r == rss_pkg::CLS_FINITE) begin
            acc_sum_r    <= sum_sat;
            acc_sum_sq_r <= sq_sat;
            if (smp_r < run_min_r) begin
              run_min_r <= smp_r;
            end
            if (smp_r > run_max_r) begin
              run_max_r <= smp_r;
            end
            if (finite_cnt_r != rss_pkg::CNT_MAX) begin
              finite_cnt_r <= finite_cnt_r + 1'b1;
            end
          end else if (cls_r == rss_pkg::CLS_INF) begin
            if (inf_cnt_r != rss_pkg::CNT_MAX) begin
              inf_cnt_r <= inf_cnt_r + 1'b1;
            end
          end else begin
            if (nan_cnt_r != rss_pkg::CNT_MAX) begin
              nan_cnt_r <= nan_cnt_r + 1'b1;
            end
          end
          state_r <= last_r ? ST_PREP : ST_IDLE;
        end
        ST_PREP: begin
          if (finite_cnt_r == '0) begin
            none_r  <= 1'b1;
            avg_r   <= '0;
            var_r   <= '0;
            state_r <= ST_FINISH;
          end else begin
            none_r  <= 1'b0;
            state_r <= ST_DIV_SUM;
          end
        end
        ST_DIV_SUM: begin
          if (div_rsp.done) begin
            state_r <= ST_AVG_FIX;
          end
        end
        ST_AVG_FIX: begin
          avg_r   <= avg_fix;
          state_r <= ST_DIV_SQ;
        end
        ST_DIV_SQ: begin
          if (div_rsp.done) begin
            state_r <= ST_MUL_AVG;
          end
        end
        ST_MUL_AVG: begin
          prod_r  <= unsigned'(mul_p);
          state_r <= ST_VAR;
        end
        ST_VAR: begin
          var_r   <= var_fix;
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            o_total_r    <= rss_pkg::CNT_W'(all_cnt_r);
            o_nan_r      <= rss_pkg::CNT_W'(nan_cnt_r);
            o_inf_r      <= rss_pkg::CNT_W'(inf_cnt_r);
            o_normal_r   <= rss_pkg::CNT_W'(finite_cnt_r);
            o_sum_r      <= acc_sum_r;
            o_avg_r      <= avg_r;
            o_var_r      <= var_r;
            o_min_r      <= run_min_r;
            o_max_r      <= run_max_r;
            o_none_r     <= none_r;
            acc_sum_r    <= '0;
            acc_sum_sq_r <= '0;
            run_min_r    <= rss_pkg::SMP_MAX;
            run_max_r    <= rss_pkg::SMP_MIN;
            finite_cnt_r <= '0;
            nan_cnt_r    <= '0;
            inf_cnt_r    <= '0;
            all_cnt_r    <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.total_count  = o_total_r;
  assign out_ch.nan_count    = o_nan_r;
  assign out_ch.inf_count    = o_inf_r;
  assign out_ch.normal_count = o_normal_r;
  assign out_ch.sum_out      = o_sum_r;
  assign out_ch.average      = o_avg_r;
  assign out_ch.variance     = o_var_r;
  assign out_ch.minimum      = o_min_r;
  assign out_ch.maximum      = o_max_r;
  assign out_ch.no_finite    = o_none_r;

`ifndef SYNTHESIS
  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (all_cnt_r >= finite_cnt_r) && (all_cnt_r >= nan_cnt_r) && (all_cnt_r >= inf_cnt_r))
    else $error("total count fell below a class count");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (finite_cnt_r != '0) |-> (run_min_r <= run_max_r))
    else $error("running minimum above running maximum");

  a_plain_item_turns: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.last_sample) |-> ##3 (state_r == ST_IDLE))
    else $error("sample without last flag did not free the input in three cycles");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == ST_DIV_SUM) || (state_r == ST_DIV_SQ)))
    else $error("divider finished outside a divide step");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_none_r) |-> ((o_avg_r == '0) && (o_var_r == '0) && (o_normal_r == '0)))
    else $error("empty data set reported a nonzero average or variance");
`endif

endmodule

`default_nettype wire

// ----- sim/rss_stats_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_stats_checker: result checker for the running sample statistics block
// Watches the sample and result channels, keeps its own running statistics of
// every accepted sample, and compares each result item, field by field, with
// the oldest expected result. Failures are counted and handed to the bench.
// ----------------------------------------------------------------------------

module rss_stats_checker (
  input  logic clk,
  input  logic rst_n,
  rss_in_if    in_ch,
  rss_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_results,
  output int   results_checked
);

  import rss_pkg::*;

  typedef struct packed {
    logic        [CNT_W-1:0] total_count;
    logic        [CNT_W-1:0] nan_count;
    logic        [CNT_W-1:0] inf_count;
    logic        [CNT_W-1:0] normal_count;
    logic signed [SUM_W-1:0] sum_out;
    logic signed [SMP_W-1:0] average;
    logic        [VAR_W-1:0] variance;
    logic signed [SMP_W-1:0] minimum;
    logic signed [SMP_W-1:0] maximum;
    logic                    no_finite;
  } stats_rec_t;

  logic signed [SUM_W-1:0] sum_acc;
  logic        [SQ_W-1:0]  sq_acc;
  logic signed [SMP_W-1:0] low_mark;
  logic signed [SMP_W-1:0] high_mark;
  logic        [CNT_W-1:0] finite_n;
  logic        [CNT_W-1:0] nan_n;
  logic        [CNT_W-1:0] inf_n;
  logic        [CNT_W-1:0] all_n;

  stats_rec_t expected_stats_q[$];
  int         fail_n;
  int         checked_n;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic string describe(input stats_rec_t r);
    return $sformatf({"total=%0d nan=%0d inf=%0d finite=%0d sum=%0d avg=%0d",
                      " var=%0d min=%0d max=%0d none=%0b"},
                     r.total_count, r.nan_count, r.inf_count, r.normal_count,
                     r.sum_out, r.average, r.variance, r.minimum, r.maximum,
                     r.no_finite);
  endfunction

  task automatic clear_accumulators();
    sum_acc   = '0;
    sq_acc    = '0;
    low_mark  = SMP_MAX;
    high_mark = SMP_MIN;
    finite_n  = '0;
    nan_n     = '0;
    inf_n     = '0;
    all_n     = '0;
  endtask

  task automatic accumulate_sample(input logic signed [SMP_W-1:0] value,
                                   input logic [CLS_W-1:0] cls, input logic last);
    longint      v;
    longint      wide_sum;
    logic [63:0] wide_sq;
    longint      n;
    longint      mean_sq;
    longint      avg;
    longint      avg_sq;
    stats_rec_t  rec;
    v = longint'(value);
    all_n = bump(all_n);
    if (cls == CLS_FINITE) begin
      wide_sum = longint'(sum_acc) + v;
      if (wide_sum > longint'(SUM_MAX)) wide_sum = longint'(SUM_MAX);
      if (wide_sum < longint'(SUM_MIN)) wide_sum = longint'(SUM_MIN);
      sum_acc = SUM_W'(wide_sum);
      wide_sq = 64'(sq_acc) + 64'(v * v);
      sq_acc = (wide_sq > 64'(SQ_MAX)) ? SQ_MAX : SQ_W'(wide_sq);
      if (value < low_mark) low_mark = value;
      if (value > high_mark) high_mark = value;
      finite_n = bump(finite_n);
    end else if (cls == CLS_INF) begin
      inf_n = bump(inf_n);
    end else begin
      nan_n = bump(nan_n);
    end
    if (!last) return;

    rec              = '0;
    rec.total_count  = all_n;
    rec.nan_count    = nan_n;
    rec.inf_count    = inf_n;
    rec.normal_count = finite_n;
    rec.sum_out      = sum_acc;
    rec.minimum      = low_mark;
    rec.maximum      = high_mark;
    rec.no_finite    = (finite_n == '0);
    if (finite_n != '0) begin
      n = longint'(finite_n);
      avg = longint'(sum_acc) / n;
      if (avg > longint'(AVG_MAX)) avg = longint'(AVG_MAX);
      if (avg < longint'(AVG_MIN)) avg = longint'(AVG_MIN);
      mean_sq = longint'(sq_acc) / n;
      avg_sq = avg * avg;
      rec.average = SMP_W'(avg);
      if (mean_sq > avg_sq) begin
        rec.variance = (mean_sq - avg_sq > longint'(VAR_MAX)) ? VAR_MAX
                                                              : VAR_W'(mean_sq - avg_sq);
      end
    end
    expected_stats_q.push_back(rec);
    clear_accumulators();
  endtask

  always @(posedge clk) begin
    stats_rec_t got;
    stats_rec_t want;
    string      bad;
    if (!rst_n) begin
      clear_accumulators();
      expected_stats_q.delete();
      fail_n    = 0;
      checked_n = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.total_count  = out_ch.total_count;
        got.nan_count    = out_ch.nan_count;
        got.inf_count    = out_ch.inf_count;
        got.normal_count = out_ch.normal_count;
        got.sum_out      = out_ch.sum_out;
        got.average      = out_ch.average;
        got.variance     = out_ch.variance;
        got.minimum      = out_ch.minimum;
        got.maximum      = out_ch.maximum;
        got.no_finite    = out_ch.no_finite;
        if (expected_stats_q.size() == 0) begin
          if (fail_n < 10) begin
            $display("[%0t] result item with no expected result: %s", $time, describe(got));
          end
          fail_n++;
        end else begin
          want = expected_stats_q.pop_front();
          bad = "";
          if (got.total_count !== want.total_count) bad = {bad, " total_count"};
          if (got.nan_count !== want.nan_count) bad = {bad, " nan_count"};
          if (got.inf_count !== want.inf_count) bad = {bad, " inf_count"};
          if (got.normal_count !== want.normal_count) bad = {bad, " normal_count"};
          if (got.sum_out !== want.sum_out) bad = {bad, " sum_out"};
          if (got.average !== want.average) bad = {bad, " average"};
          if (got.variance !== want.variance) bad = {bad, " variance"};
          if (got.minimum !== want.minimum) bad = {bad, " minimum"};
          if (got.maximum !== want.maximum) bad = {bad, " maximum"};
          if (got.no_finite !== want.no_finite) bad = {bad, " no_finite"};
          if (bad != "") begin
            if (fail_n < 10) begin
              $display("[%0t] result %0d differs in:%s", $time, checked_n, bad);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            fail_n++;
          end
          checked_n++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        accumulate_sample(in_ch.sample, in_ch.sample_class, in_ch.last_sample);
      end
    end
    mismatch_count  <= fail_n;
    pending_results <= expected_stats_q.size();
    results_checked <= checked_n;
  end

endmodule

// ----- sim/tb_running_sample_statistics_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_sample_statistics_top: bench for the running statistics block
// Drives directed edge-case data sets and random data sets with random idle
// gaps on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------

module tb_running_sample_statistics_top;

  import rss_pkg::*;

  localparam logic [CLS_W-1:0] CLS_NAN   = 2'd2;
  localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_LIMIT  = 4000;

  logic clk;
  logic rst_n;
  bit   sink_steady;
  int   samples_sent;
  int   sets_sent;
  int   quiet_cycles;
  int   mismatch_count;
  int   pending_results;
  int   results_checked;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  running_sample_statistics_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rss_stats_checker stats_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic push_sample(input logic signed [SMP_W-1:0] value,
                             input logic [CLS_W-1:0] cls, input logic last, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= value;
    in_ch.sample_class <= cls;
    in_ch.last_sample  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    if (last) sets_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
      $display("FAIL running_sample_statistics_top");
      $finish;
    end
  end

  initial begin
    int                      random_items;
    int                      set_len;
    int                      kind;
    int                      r;
    bit                      burst;
    logic signed [SMP_W-1:0] value;
    logic [CLS_W-1:0]        cls;

    rst_n              = 1'b0;
    sink_steady        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.sample_class = CLS_FINITE;
    in_ch.last_sample  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets: extremes, non-finite only, equal samples, every class tag.
    push_sample(SMP_MAX, CLS_FINITE, 1'b1, 0);
    push_sample(SMP_MIN, CLS_FINITE, 1'b0, 0);
    push_sample(SMP_MAX, CLS_FINITE, 1'b0, 1);
    push_sample(24'sd0, CLS_FINITE, 1'b0, 0);
    push_sample(-24'sd1, CLS_FINITE, 1'b0, 2);
    push_sample(24'sh555555, CLS_INF, 1'b1, 0);
    push_sample(24'sh2AAAAA, CLS_NAN, 1'b0, 0);
    push_sample(SMP_MAX, CLS_SPARE, 1'b0, 0);
    push_sample(SMP_MIN, CLS_INF, 1'b0, 0);
    push_sample(24'sd7, CLS_NAN, 1'b1, 0);
    push_sample(24'sd100, CLS_INF, 1'b1, 0);
    push_sample(24'sd4096, CLS_FINITE, 1'b0, 0);
    push_sample(-24'sd4096, CLS_FINITE, 1'b0, 0);
    push_sample(24'sd4096, CLS_FINITE, 1'b0, 3);
    push_sample(-24'sd4096, CLS_FINITE, 1'b0, 0);
    push_sample(-24'sd9, CLS_SPARE, 1'b1, 0);
    push_sample(24'sd12345, CLS_FINITE, 1'b0, 0);
    push_sample(24'sd12345, CLS_FINITE, 1'b0, 0);
    push_sample(24'sd12345, CLS_FINITE, 1'b1, 0);
    push_sample(SMP_MIN, CLS_NAN, 1'b1, 0);
    wait_drained();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      set_len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                : $urandom_range(1, 12);
      kind        = $urandom_range(0, 9);
      burst       = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < set_len; k++) begin
        if (kind == 0) begin
          r = $urandom_range(0, 2);
          cls = (r == 0) ? CLS_INF : (r == 1) ? CLS_NAN : CLS_SPARE;
        end else begin
          r = $urandom_range(0, 99);
          cls = (r < 80) ? CLS_FINITE : (r < 90) ? CLS_INF : (r < 95) ? CLS_NAN : CLS_SPARE;
        end
        case (kind)
          1, 2: value = SMP_W'(int'($urandom_range(0, 8191)) - 4096);
          3: begin
            case ($urandom_range(0, 4))
              0:       value = SMP_MAX;
              1:       value = SMP_MIN;
              2:       value = '0;
              3:       value = '1;
              default: value = 24'sd1;
            endcase
          end
          default: value = SMP_W'($urandom);
        endcase
        push_sample(value, cls, k == set_len - 1, burst ? 0 : idle_len());
      end
      random_items += set_len;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    sink_steady = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Run covered %0d samples in %0d data sets, %0d results checked.",
             samples_sent, sets_sent, results_checked);
    $display("It included directed edge cases and random sets with stalls on both sides.");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASS running_sample_statistics_top");
    end else begin
      $display("FAIL running_sample_statistics_top");
    end
    $finish;
  end

endmodule

// ----- running_sample_statistics_top.f -----
rtl/rss_pkg.sv
rtl/rss_if.sv
rtl/rss_div.sv
rtl/running_sample_statistics_top.sv
sim/rss_stats_checker.sv
sim/tb_running_sample_statistics_top.sv
